>>> hw/rtl/bitmap_2d_rolling_hash_matcher_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 2D rolling hash matcher
// Shared property shapes used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BITMAP_2D_ROLLING_HASH_MATCHER_TOP_DEFINES_SVH
`define BITMAP_2D_ROLLING_HASH_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("brhm: same-cycle implication violated");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("brhm: next-cycle implication violated");

// implication that is also checked around reset
`define ASSERT_IMPLY_NORST(lbl, clk, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("brhm: reset-time implication violated");

`endif

>>> hw/rtl/brhm_pkg.sv
// ---------------------------------------------------------------------------
// brhm_pkg
// Widths, codes, constants and hash helpers for the 2D rolling hash matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package brhm_pkg;

	localparam int HASH_W     = 30;   // all hashes mod 2^30
	localparam int COUNT_W    = 23;
	localparam int DIM_W      = 12;   // width/height registers
	localparam int PH_REG_W   = 7;    // pattern height register
	localparam int POS_W      = 11;   // image row/column counters
	localparam int OPC_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam int DEF_MAX_IMAGE_WIDTH  = 2048;
	localparam int DEF_MAX_PATTERN_ROWS = 64;
	localparam int MAX_IMAGE_ROWS       = 2048;

	// shift amounts: x*17 = (x<<4)+x, x*33 = (x<<5)+x
	localparam int SH_ROW = 4;
	localparam int SH_COL = 5;

	localparam logic [OPC_W-1:0] OP_CLEAR   = 2'd0;
	localparam logic [OPC_W-1:0] OP_PATTERN = 2'd1;
	localparam logic [OPC_W-1:0] OP_IMAGE   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd3;

	typedef logic [HASH_W-1:0]  hash_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam count_t COUNT_MAX = '1;

	function automatic hash_t mul_row(hash_t a);
		return hash_t'(hash_t'(a << SH_ROW) + a);
	endfunction

	function automatic hash_t mul_col(hash_t a);
		return hash_t'(hash_t'(a << SH_COL) + a);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/brhm_if.sv
// ---------------------------------------------------------------------------
// brhm channel interfaces
// Pixel input, count output and configuration write channels.
// ---------------------------------------------------------------------------
`default_nettype none

interface brhm_in_if;
	logic                        valid;
	logic                        ready;
	logic [brhm_pkg::OPC_W-1:0]  opcode;
	logic                        pixel;

	modport source (output valid, output opcode, output pixel, input ready);
	modport sink   (input valid, input opcode, input pixel, output ready);
endinterface

interface brhm_out_if;
	logic              valid;
	logic              ready;
	brhm_pkg::count_t  match_count;

	modport source (output valid, output match_count, input ready);
	modport sink   (input valid, input match_count, output ready);
endinterface

interface brhm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [brhm_pkg::CFG_IDX_W-1:0]   index;
	logic [brhm_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bitmap_2d_rolling_hash_matcher_top.sv
// ---------------------------------------------------------------------------
// bitmap_2d_rolling_hash_matcher_top
// Counts occurrences of a binary pattern in a binary image, 2D rolling hash.
// ---------------------------------------------------------------------------
// Use:
//  - cfg: write pattern/image width and height (index 0..3) while idle.
//    Always ready. All four registers reset to 1.
//  - pix: opcode 0 clears the job, 1 streams a pattern pixel, 2 streams an
//    image pixel (both raster order), 3 is dropped. One transfer per cycle while pix.ready is high.
//  - res: one match_count after the last pixel of each image.
// Timing: pattern pixels act in the accept cycle. An image pixel runs through
//  four registered steps (memory read, window hash and ring multiply, column
//  hash update, compare and count), and the count then goes to the output
//  register for res. Sustained rate one pixel per cycle while not stalled;
//  each line store sees a read and a write per pixel.
// Reset: the job and registers clear at once; the line and hash stores are
//  not cleared and need no sweep, the block is ready straight away.
// Stall: a held count does not block input; only when a second count is
//  ready behind an untaken one does the whole pipeline freeze and pix.ready
//  fall until res is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_2d_rolling_hash_matcher_top #(
	parameter int MAX_IMAGE_WIDTH  = brhm_pkg::DEF_MAX_IMAGE_WIDTH,
	parameter int MAX_PATTERN_ROWS = brhm_pkg::DEF_MAX_PATTERN_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	brhm_cfg_if.sink         cfg,
	brhm_in_if.sink          pix,
	brhm_out_if.source       res
);

	// index widths of the stores
	localparam int CW = (MAX_IMAGE_WIDTH  > 1) ? $clog2(MAX_IMAGE_WIDTH)  : 1;
	localparam int RW = (MAX_PATTERN_ROWS > 1) ? $clog2(MAX_PATTERN_ROWS) : 1;
	// one spare bit for the +1 compares
	localparam int EXT_W = brhm_pkg::DIM_W + 1;
	// clamp limits, kept within what the registers can hold
	localparam int DIM_MAX = (1 << brhm_pkg::DIM_W) - 1;
	localparam int PHR_MAX = (1 << brhm_pkg::PH_REG_W) - 1;
	localparam int PW_HI   = (MAX_IMAGE_WIDTH  > DIM_MAX) ? DIM_MAX : MAX_IMAGE_WIDTH;
	localparam int PH_HI   = (MAX_PATTERN_ROWS > PHR_MAX) ? PHR_MAX : MAX_PATTERN_ROWS;
	localparam int IH_HI   = (brhm_pkg::MAX_IMAGE_ROWS > DIM_MAX) ? DIM_MAX
	                         : brhm_pkg::MAX_IMAGE_ROWS;

	// per-pixel control carried down the pipeline
	typedef struct packed {
		logic          img;        // image pixel, else job clear
		logic          px;
		logic          first_col;  // column 0: window restarts
		logic          drop;       // a pixel leaves the window
		logic          win;        // a full window ends here
		logic          row_first;  // image row 0
		logic          row_roll;   // oldest ring row leaves the column
		logic          row_cnt;    // column window complete, compare
		logic          last;       // last pixel of the image
		logic [CW-1:0] j;          // window start column
		logic [RW-1:0] rrow;       // ring row
	} ctl_t;

	// -----------------------------------------------------------------------
	// Configuration registers
	// -----------------------------------------------------------------------
	logic [brhm_pkg::DIM_W-1:0]    pattern_width_q, image_width_q, image_height_q;
	logic [brhm_pkg::PH_REG_W-1:0] pattern_height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_width_q  <= brhm_pkg::DIM_W'(1);
			pattern_height_q <= brhm_pkg::PH_REG_W'(1);
			image_width_q    <= brhm_pkg::DIM_W'(1);
			image_height_q   <= brhm_pkg::DIM_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				brhm_pkg::REG_PATTERN_WIDTH:  pattern_width_q  <= cfg.data;
				brhm_pkg::REG_PATTERN_HEIGHT: pattern_height_q <= cfg.data[brhm_pkg::PH_REG_W-1:0];
				brhm_pkg::REG_IMAGE_WIDTH:    image_width_q    <= cfg.data;
				brhm_pkg::REG_IMAGE_HEIGHT:   image_height_q   <= cfg.data;
			endcase
		end
	end

	// effective sizes, zero reads as one, values over the limit clamp
	logic [brhm_pkg::DIM_W-1:0]    pw, iw, ih;
	logic [brhm_pkg::PH_REG_W-1:0] ph;

	always_comb begin
		pw = pattern_width_q;
		if (pattern_width_q == '0)
			pw = brhm_pkg::DIM_W'(1);
		else if (pattern_width_q > brhm_pkg::DIM_W'(PW_HI))
			pw = brhm_pkg::DIM_W'(PW_HI);

		ph = pattern_height_q;
		if (pattern_height_q == '0)
			ph = brhm_pkg::PH_REG_W'(1);
		else if (pattern_height_q > brhm_pkg::PH_REG_W'(PH_HI))
			ph = brhm_pkg::PH_REG_W'(PH_HI);

		iw = image_width_q;
		if (image_width_q == '0)
			iw = brhm_pkg::DIM_W'(1);
		else if (image_width_q > brhm_pkg::DIM_W'(PW_HI))
			iw = brhm_pkg::DIM_W'(PW_HI);

		ih = image_height_q;
		if (image_height_q == '0)
			ih = brhm_pkg::DIM_W'(1);
		else if (image_height_q > brhm_pkg::DIM_W'(IH_HI))
			ih = brhm_pkg::DIM_W'(IH_HI);
	end

	logic [EXT_W-1:0] pw_ext, ph_ext, iw_ext, ih_ext;
	assign pw_ext = EXT_W'(pw);
	assign ph_ext = EXT_W'(ph);
	assign iw_ext = EXT_W'(iw);
	assign ih_ext = EXT_W'(ih);

	// -----------------------------------------------------------------------
	// Handshake and pipeline enable
	// -----------------------------------------------------------------------
	logic en, pix_acc, img_acc, enter;
	logic v_s1, v_s2, v_s3;
	ctl_t ctl_s0, ctl_s1, ctl_s2, ctl_s3;
	logic out_valid_q;
	brhm_pkg::count_t match_count_q;

	// freeze only when a count is ready behind an untaken one
	assign en = !(v_s3 && ctl_s3.img && ctl_s3.last && out_valid_q && !res.ready);

	assign pix.ready = en;
	assign pix_acc   = pix.valid && pix.ready;
	assign img_acc   = pix_acc && (pix.opcode == brhm_pkg::OP_IMAGE);
	assign enter     = pix_acc && ((pix.opcode == brhm_pkg::OP_IMAGE) ||
	                               (pix.opcode == brhm_pkg::OP_CLEAR));

	// -----------------------------------------------------------------------
	// Pattern load: row hash, pattern hash and the two leading powers
	// -----------------------------------------------------------------------
	brhm_pkg::hash_t pat_hash_q, pat_acc_q, row_mul_q, col_mul_q;
	logic [brhm_pkg::DIM_W-1:0]    pat_col_q;
	logic [brhm_pkg::PH_REG_W-1:0] pat_row_q;
	logic            pat_active, pat_row_end;
	brhm_pkg::hash_t pat_acc_nxt;

	assign pat_active  = pat_row_q < ph;
	assign pat_row_end = (EXT_W'(pat_col_q) + EXT_W'(1)) >= pw_ext;
	assign pat_acc_nxt = brhm_pkg::hash_t'(brhm_pkg::mul_row(pat_acc_q) +
	                                       brhm_pkg::hash_t'(pix.pixel));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_hash_q <= '0;
			pat_acc_q  <= '0;
			row_mul_q  <= brhm_pkg::hash_t'(1);
			col_mul_q  <= brhm_pkg::hash_t'(1);
			pat_col_q  <= '0;
			pat_row_q  <= '0;
		end else if (pix_acc) begin
			if (pix.opcode == brhm_pkg::OP_CLEAR) begin
				pat_hash_q <= '0;
				pat_acc_q  <= '0;
				row_mul_q  <= brhm_pkg::hash_t'(1);
				col_mul_q  <= brhm_pkg::hash_t'(1);
				pat_col_q  <= '0;
				pat_row_q  <= '0;
			end else if (pix.opcode == brhm_pkg::OP_PATTERN && pat_active) begin
				// 17^(W-1) grows along the first row, 33^(H-1) once per later row
				if (pat_row_q == '0 && pat_col_q != '0)
					row_mul_q <= brhm_pkg::mul_row(row_mul_q);
				if (pat_col_q == '0 && pat_row_q != '0)
					col_mul_q <= brhm_pkg::mul_col(col_mul_q);
				if (pat_row_end) begin
					pat_hash_q <= brhm_pkg::hash_t'(brhm_pkg::mul_col(pat_hash_q) + pat_acc_nxt);
					pat_acc_q  <= '0;
					pat_col_q  <= '0;
					pat_row_q  <= pat_row_q + brhm_pkg::PH_REG_W'(1);
				end else begin
					pat_acc_q  <= pat_acc_nxt;
					pat_col_q  <= pat_col_q + brhm_pkg::DIM_W'(1);
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Image position and per-pixel decode (accept cycle)
	// -----------------------------------------------------------------------
	logic [brhm_pkg::POS_W-1:0] img_col_q, img_row_q;
	logic [RW-1:0]              ring_row_q;
	logic [EXT_W-1:0]           c_ext, r_ext, j_full, bd_full;
	logic [CW-1:0]              c_idx, bits_addr;
	logic                       col_end, row_last, ring_wrap;

	assign c_ext     = EXT_W'(img_col_q);
	assign r_ext     = EXT_W'(img_row_q);
	assign j_full    = c_ext + EXT_W'(1) - pw_ext;
	assign bd_full   = c_ext - pw_ext;
	assign c_idx     = CW'(img_col_q);
	assign bits_addr = bd_full[CW-1:0];
	assign col_end   = (c_ext + EXT_W'(1)) >= iw_ext;
	assign row_last  = (r_ext + EXT_W'(1)) >= ih_ext;
	assign ring_wrap = (EXT_W'(ring_row_q) + EXT_W'(1)) >= ph_ext;

	always_comb begin
		ctl_s0.img       = (pix.opcode == brhm_pkg::OP_IMAGE);
		ctl_s0.px        = pix.pixel;
		ctl_s0.first_col = (img_col_q == '0);
		ctl_s0.drop      = c_ext >= pw_ext;
		ctl_s0.win       = (c_ext + EXT_W'(1)) >= pw_ext;
		ctl_s0.row_first = (img_row_q == '0);
		ctl_s0.row_roll  = r_ext >= ph_ext;
		ctl_s0.row_cnt   = (r_ext + EXT_W'(1)) >= ph_ext;
		ctl_s0.last      = col_end && row_last;
		ctl_s0.j         = j_full[CW-1:0];
		ctl_s0.rrow      = ring_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_col_q  <= '0;
			img_row_q  <= '0;
			ring_row_q <= '0;
		end else if (pix_acc) begin
			if (pix.opcode == brhm_pkg::OP_CLEAR) begin
				img_col_q  <= '0;
				img_row_q  <= '0;
				ring_row_q <= '0;
			end else if (pix.opcode == brhm_pkg::OP_IMAGE) begin
				if (col_end) begin
					img_col_q <= '0;
					if (row_last) begin
						img_row_q  <= '0;
						ring_row_q <= '0;
					end else begin
						img_row_q  <= img_row_q + brhm_pkg::POS_W'(1);
						ring_row_q <= ring_wrap ? '0 : ring_row_q + RW'(1);
					end
				end else begin
					img_col_q <= img_col_q + brhm_pkg::POS_W'(1);
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stores. Reads are issued on accept and land in stage 1.
	// -----------------------------------------------------------------------
	logic            bits_mem [MAX_IMAGE_WIDTH];
	brhm_pkg::hash_t col_mem  [MAX_IMAGE_WIDTH];
	brhm_pkg::hash_t ring_mem [MAX_PATTERN_ROWS][MAX_IMAGE_WIDTH];

	logic            bit_rd_s1;
	brhm_pkg::hash_t col_rd_s1, ring_rd_s1;
	brhm_pkg::hash_t w_s1, col_new_s2;

	// current row pixels: read pw columns back, written earlier in the same row
	always_ff @(posedge clk) begin
		if (img_acc) begin
			bits_mem[c_idx] <= pix.pixel;
			bit_rd_s1       <= bits_mem[bits_addr];
		end
	end

	// ring of window hashes, written from stage 1
	always_ff @(posedge clk) begin
		if (img_acc)
			ring_rd_s1 <= ring_mem[ring_row_q][ctl_s0.j];
		if (en && v_s1 && ctl_s1.img && ctl_s1.win)
			ring_mem[ctl_s1.rrow][ctl_s1.j] <= w_s1;
	end

	// column hashes, written from stage 2
	always_ff @(posedge clk) begin
		if (img_acc)
			col_rd_s1 <= col_mem[ctl_s0.j];
		if (en && v_s2 && ctl_s2.img && ctl_s2.win)
			col_mem[ctl_s2.j] <= col_new_s2;
	end

	// -----------------------------------------------------------------------
	// Pipeline valids and payload
	// -----------------------------------------------------------------------
	brhm_pkg::hash_t rm_s1, cm_s1, phash_s1, phash_s2, phash_s3;
	brhm_pkg::hash_t w_s2, prod_s2, col_s2, col_s3;
	brhm_pkg::hash_t prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= enter;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// pattern state is sampled on accept so later pattern pixels keep order
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= ctl_s0;
			rm_s1    <= row_mul_q;
			cm_s1    <= col_mul_q;
			phash_s1 <= pat_hash_q;

			ctl_s2   <= ctl_s1;
			phash_s2 <= phash_s1;
			w_s2     <= w_s1;
			prod_s2  <= prod_s1;
			col_s2   <= col_rd_s1;

			ctl_s3   <= ctl_s2;
			phash_s3 <= phash_s2;
			col_s3   <= col_new_s2;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 1: window hash along the row, ring product
	// -----------------------------------------------------------------------
	brhm_pkg::hash_t acc_q, sub_s1, ring_op_s1;
	logic            rw_v_q;
	logic [RW-1:0]   rw_row_q;
	logic [CW-1:0]   rw_j_q;
	brhm_pkg::hash_t rw_val_q;

	assign sub_s1 = (ctl_s1.drop && bit_rd_s1) ? rm_s1 : '0;
	assign w_s1   = ctl_s1.first_col ? brhm_pkg::hash_t'(ctl_s1.px)
	              : brhm_pkg::hash_t'(brhm_pkg::mul_row(brhm_pkg::hash_t'(acc_q - sub_s1)) +
	                                  brhm_pkg::hash_t'(ctl_s1.px));

	// the ring entry may have been written on the very edge it was read
	assign ring_op_s1 = (rw_v_q && rw_row_q == ctl_s1.rrow && rw_j_q == ctl_s1.j)
	                  ? rw_val_q : ring_rd_s1;
	assign prod_s1    = ring_op_s1 * cm_s1;

	always_ff @(posedge clk) begin
		if (en && v_s1 && ctl_s1.img)
			acc_q <= w_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rw_v_q <= 1'b0;
		else if (en && v_s1 && ctl_s1.img && ctl_s1.win)
			rw_v_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en && v_s1 && ctl_s1.img && ctl_s1.win) begin
			rw_row_q <= ctl_s1.rrow;
			rw_j_q   <= ctl_s1.j;
			rw_val_q <= w_s1;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 2: column hash rolls down the rows
	// -----------------------------------------------------------------------
	// last two column writes; either may have landed after this pixel's read
	logic            cw1_v_q, cw2_v_q;
	logic [CW-1:0]   cw1_j_q, cw2_j_q;
	brhm_pkg::hash_t cw1_val_q, cw2_val_q, col_op_s2;

	always_comb begin
		if (cw1_v_q && cw1_j_q == ctl_s2.j)
			col_op_s2 = cw1_val_q;
		else if (cw2_v_q && cw2_j_q == ctl_s2.j)
			col_op_s2 = cw2_val_q;
		else
			col_op_s2 = col_s2;

		if (ctl_s2.row_first)
			col_new_s2 = w_s2;
		else if (ctl_s2.row_roll)
			col_new_s2 = brhm_pkg::hash_t'(
				brhm_pkg::mul_col(brhm_pkg::hash_t'(col_op_s2 - prod_s2)) + w_s2);
		else
			col_new_s2 = brhm_pkg::hash_t'(brhm_pkg::mul_col(col_op_s2) + w_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw1_v_q <= 1'b0;
			cw2_v_q <= 1'b0;
		end else if (en && v_s2 && ctl_s2.img && ctl_s2.win) begin
			cw1_v_q <= 1'b1;
			cw2_v_q <= cw1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2 && ctl_s2.img && ctl_s2.win) begin
			cw1_j_q   <= ctl_s2.j;
			cw1_val_q <= col_new_s2;
			cw2_j_q   <= cw1_j_q;
			cw2_val_q <= cw1_val_q;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 3: compare, count, hand the count to the output register
	// -----------------------------------------------------------------------
	brhm_pkg::count_t cnt_q, cnt_nxt;
	logic             hit_s3;

	assign hit_s3  = ctl_s3.win && ctl_s3.row_cnt && (col_s3 == phash_s3) &&
	                 (cnt_q != brhm_pkg::COUNT_MAX);
	assign cnt_nxt = cnt_q + brhm_pkg::count_t'(hit_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (en && v_s3) begin
			if (!ctl_s3.img || ctl_s3.last)
				cnt_q <= '0;
			else
				cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en && v_s3 && ctl_s3.img && ctl_s3.last)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en && v_s3 && ctl_s3.img && ctl_s3.last)
			match_count_q <= cnt_nxt;
	end

	assign res.valid       = out_valid_q;
	assign res.match_count = match_count_q;

endmodule

`default_nettype wire

>>> hw/rtl/brhm_checker.sv
// ---------------------------------------------------------------------------
// brhm_checker
// Port-level checks for the 2D rolling hash matcher, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bitmap_2d_rolling_hash_matcher_top_defines.svh"

module brhm_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_ready,
	input  wire logic             res_valid,
	input  wire logic             res_ready,
	input  wire brhm_pkg::count_t res_count,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready
);

	// input only backs up behind an untaken count
	`ASSERT_IMPLY(a_stall_only_when_blocked, clk, arst_n, !pix_ready, res_valid && !res_ready)

	// a waiting count holds
	`ASSERT_NEXT(a_count_held, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_count))

	// register writes never wait
	`ASSERT_IMPLY(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

	// nothing offered straight out of reset
	`ASSERT_IMPLY_NORST(a_empty_after_reset, clk, $rose(arst_n), !res_valid)

endmodule

bind bitmap_2d_rolling_hash_matcher_top brhm_checker u_brhm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_ready (pix.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_count (res.match_count),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

`default_nettype wire

>>> tb/bitmap_2d_rolling_hash_matcher_top_checker.sv
// ---------------------------------------------------------------------------
// Match count checker for the 2D rolling hash matcher
// Watches the configuration, pixel and count channels, tracks the job state
// of the matcher pixel by pixel and compares every count that leaves the
// block with the oldest count still owed.
// ---------------------------------------------------------------------------
module bitmap_2d_rolling_hash_matcher_top_checker #(
	parameter int MAX_IMAGE_WIDTH  = brhm_pkg::DEF_MAX_IMAGE_WIDTH,
	parameter int MAX_PATTERN_ROWS = brhm_pkg::DEF_MAX_PATTERN_ROWS
) (
	input  logic  clk,
	input  logic  arst_n,
	brhm_cfg_if   cfg,
	brhm_in_if    pix,
	brhm_out_if   res,
	output int    failures,
	output int    outstanding,
	output int    counts_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import brhm_pkg::*;

	localparam int    RING_DEPTH = MAX_PATTERN_ROWS * MAX_IMAGE_WIDTH;
	localparam hash_t ROW_BASE   = 30'd17;
	localparam hash_t COL_BASE   = 30'd33;

	// register copies
	logic [DIM_W-1:0]    pw_reg, iw_reg, ih_reg;
	logic [PH_REG_W-1:0] ph_reg;

	// job state
	hash_t       pat_hash, pat_row_hash, row_top_weight, col_top_weight;
	int unsigned pat_pos, img_row, img_col;
	hash_t       window_hash;
	count_t      match_tally;

	// line and hash stores
	bit    line_bits   [MAX_IMAGE_WIDTH];
	hash_t row_ring    [RING_DEPTH];
	hash_t column_sums [MAX_IMAGE_WIDTH];

	count_t owed_counts [$];

	function automatic int unsigned effective_dim(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic report(input string what);
		failures++;
		$display("[%0t] count check: %s", $time, what);
	endtask

	task automatic clear_job();
		pat_hash       = '0;
		pat_row_hash   = '0;
		row_top_weight = hash_t'(1);
		col_top_weight = hash_t'(1);
		pat_pos        = 0;
		img_row        = 0;
		img_col        = 0;
		window_hash    = '0;
		match_tally    = '0;
	endtask

	task automatic take_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_PATTERN_WIDTH:  pw_reg = data[DIM_W-1:0];
			REG_PATTERN_HEIGHT: ph_reg = data[PH_REG_W-1:0];
			REG_IMAGE_WIDTH:    iw_reg = data[DIM_W-1:0];
			REG_IMAGE_HEIGHT:   ih_reg = data[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic take_pixel(input logic [OPC_W-1:0] op, input logic px);
		int unsigned pw, ph, iw, ih, col, r, c, j, slot;
		hash_t drop;
		pw = effective_dim(pw_reg, MAX_IMAGE_WIDTH);
		ph = effective_dim(ph_reg, MAX_PATTERN_ROWS);
		iw = effective_dim(iw_reg, MAX_IMAGE_WIDTH);
		ih = effective_dim(ih_reg, MAX_IMAGE_ROWS);
		case (op)
			OP_CLEAR: clear_job();
			OP_PATTERN: begin
				// pixels past the end of the pattern change nothing
				if (pat_pos < pw * ph) begin
					col = pat_pos % pw;
					if (pat_pos > 0 && pat_pos < pw)
						row_top_weight = row_top_weight * ROW_BASE;
					if (col == 0 && pat_pos > 0)
						col_top_weight = col_top_weight * COL_BASE;
					pat_row_hash = pat_row_hash * ROW_BASE + hash_t'(px);
					if (col == pw - 1) begin
						pat_hash     = pat_hash * COL_BASE + pat_row_hash;
						pat_row_hash = '0;
					end
					pat_pos++;
				end
			end
			OP_IMAGE: begin
				r = img_row & 32'h7FF;
				c = img_col & 32'h7FF;
				line_bits[c] = px;
				// horizontal window over the last pw pixels of the row
				if (c == 0) begin
					window_hash = hash_t'(px);
				end else if (c >= pw) begin
					drop = line_bits[c - pw] ? row_top_weight : '0;
					window_hash = (window_hash - drop) * ROW_BASE + hash_t'(px);
				end else begin
					window_hash = window_hash * ROW_BASE + hash_t'(px);
				end
				// vertical window over the last ph window hashes
				if (c + 1 >= pw) begin
					j    = c + 1 - pw;
					slot = (r % ph) * MAX_IMAGE_WIDTH + j;
					if (r == 0)
						column_sums[j] = window_hash;
					else if (r >= ph)
						column_sums[j] = (column_sums[j] - row_ring[slot] * col_top_weight)
							* COL_BASE + window_hash;
					else
						column_sums[j] = column_sums[j] * COL_BASE + window_hash;
					row_ring[slot] = window_hash;
					if (r + 1 >= ph && column_sums[j] == pat_hash && match_tally != COUNT_MAX)
						match_tally++;
				end
				if (c + 1 >= iw) begin
					img_col = 0;
					if (r + 1 >= ih) begin
						owed_counts.push_back(match_tally);
						img_row     = 0;
						match_tally = '0;
					end else begin
						img_row = r + 1;
					end
				end else begin
					img_col = c + 1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_count(input count_t got);
		count_t want;
		if (owed_counts.size() == 0) begin
			report($sformatf("match_count %0d arrived with none owed", got));
		end else begin
			want = owed_counts.pop_front();
			counts_checked++;
			if (got !== want)
				report($sformatf("match_count %0d, expected %0d", got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_reg = 1;
			ph_reg = 1;
			iw_reg = 1;
			ih_reg = 1;
			clear_job();
			owed_counts.delete();
			failures       = 0;
			outstanding    = 0;
			counts_checked = 0;
		end else begin
			// a count can never leave in the cycle its last pixel enters
			if (res.valid && res.ready)
				check_count(res.match_count);
			if (cfg.valid && cfg.ready)
				take_write(cfg.index, cfg.data);
			if (pix.valid && pix.ready)
				take_pixel(pix.opcode, pix.pixel);
			outstanding = owed_counts.size();
		end
	end

endmodule

>>> tb/bitmap_2d_rolling_hash_matcher_top_test.sv
// ---------------------------------------------------------------------------
// Testbench top for the 2D rolling hash matcher
// Drives configuration writes and pattern/image pixel streams into the
// matcher, stalls the count output at random and leaves the checking to the
// count checker beside it. A short directed run comes first, then the widest
// and tallest settings, then random jobs on small bitmaps.
// ---------------------------------------------------------------------------
module bitmap_2d_rolling_hash_matcher_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import brhm_pkg::*;

	// opcode the block drops without effect
	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

	localparam int IDLE_MAX       = 18;    // longest gap / stall per transfer
	localparam int SETTLE_CYCLES  = 12;    // pipeline is four stages deep
	localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
	localparam int RANDOM_PIXELS  = 950;
	localparam int RANDOM_COUNTS  = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	brhm_cfg_if cfg ();
	brhm_in_if  pix ();
	brhm_out_if res ();

	int failures, outstanding, counts_checked;

	bitmap_2d_rolling_hash_matcher_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix    (pix),
		.res    (res)
	);

	bitmap_2d_rolling_hash_matcher_top_checker count_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.pix            (pix),
		.res            (res),
		.failures       (failures),
		.outstanding    (outstanding),
		.counts_checked (counts_checked)
	);

	always #5 clk = ~clk;

	// idling limits for the current job, 0 gives a stretch with no idling
	int gap_max   = 0;
	int stall_max = 0;

	// effective sizes of the current setting, as the block clamps them
	int cur_pw = 1, cur_ph = 1, cur_iw = 1, cur_ih = 1;
	int density;
	int pixels_sent = 0;
	int job_setups  = 0;

	bit pat_bits [];
	bit img_bits [];

	function automatic int effective_dim(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// ---------------------------------------------------------------------
	// Pixel channel: one transfer per call, changes at the falling edge.
	// valid is only dropped when a gap is drawn, so back-to-back transfers
	// keep it high without a second assignment in the same step.
	// ---------------------------------------------------------------------
	task automatic send_pixel(input logic [OPC_W-1:0] op, input logic px);
		int gap;
		gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix.valid  <= 1'b1;
		pix.opcode <= op;
		pix.pixel  <= px;
		do @(posedge clk); while (pix.ready !== 1'b1);
		@(negedge clk);
	endtask

	// all four registers in one burst, valid held high throughout
	task automatic write_config(input logic [CFG_DATA_W-1:0] pw_d, ph_d, iw_d, ih_d);
		logic [CFG_DATA_W-1:0] vals [4];
		logic [CFG_IDX_W-1:0]  regs [4];
		vals = '{pw_d, ph_d, iw_d, ih_d};
		regs = '{REG_PATTERN_WIDTH, REG_PATTERN_HEIGHT, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
		cfg.valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg.index <= regs[i];
			cfg.data  <= vals[i];
			do @(posedge clk); while (cfg.ready !== 1'b1);
			@(negedge clk);
		end
		cfg.valid <= 1'b0;
		cur_pw = effective_dim(pw_d, DEF_MAX_IMAGE_WIDTH);
		cur_ph = effective_dim(ph_d[PH_REG_W-1:0], DEF_MAX_PATTERN_ROWS);
		cur_iw = effective_dim(iw_d, DEF_MAX_IMAGE_WIDTH);
		cur_ih = effective_dim(ih_d, MAX_IMAGE_ROWS);
		job_setups++;
	endtask

	// hold the sender off until every count owed is in, then let the
	// pipeline drain pixels that owe nothing
	task automatic settle();
		pix.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic pick_idling();
		gap_max   = ($urandom_range(2, 0) == 0) ? 0 : IDLE_MAX;
		stall_max = ($urandom_range(2, 0) == 0) ? 0 : IDLE_MAX;
	endtask

	task automatic make_pattern();
		case ($urandom_range(3, 0))
			0: density = 15;
			1: density = 85;
			default: density = 50;
		endcase
		pat_bits = new[cur_pw * cur_ph];
		foreach (pat_bits[i]) pat_bits[i] = ($urandom_range(99, 0) < density);
	endtask

	// random image of the same density with copies of the pattern dropped in
	task automatic make_image(input int plants);
		int r0, c0;
		img_bits = new[cur_iw * cur_ih];
		foreach (img_bits[i]) img_bits[i] = ($urandom_range(99, 0) < density);
		if (cur_pw <= cur_iw && cur_ph <= cur_ih) begin
			repeat (plants) begin
				r0 = $urandom_range(cur_ih - cur_ph, 0);
				c0 = $urandom_range(cur_iw - cur_pw, 0);
				for (int y = 0; y < cur_ph; y++)
					for (int x = 0; x < cur_pw; x++)
						img_bits[(r0 + y) * cur_iw + c0 + x] = pat_bits[y * cur_pw + x];
			end
		end
	endtask

	task automatic load_pattern(input int first, input int last);
		for (int i = first; i < last; i++) begin
			send_pixel(OP_PATTERN, pat_bits[i]);
			pixels_sent++;
		end
	endtask

	// sends the first stop pixels of the image; pattern pixels from
	// pattern_next on are slipped in between while any remain
	task automatic send_image(input bit with_noise, input int pattern_next, input int stop);
		int next;
		next = pattern_next;
		for (int i = 0; i < stop; i++) begin
			if (next < pat_bits.size() && $urandom_range(2, 0) == 0) begin
				send_pixel(OP_PATTERN, pat_bits[next]);
				next++;
				pixels_sent++;
			end else if (with_noise && $urandom_range(15, 0) == 0) begin
				// dropped opcode, or a pattern pixel past the end of the pattern
				send_pixel(($urandom_range(1, 0) != 0) ? OP_UNUSED : OP_PATTERN,
					1'($urandom));
			end
			send_pixel(OP_IMAGE, img_bits[i]);
			pixels_sent++;
		end
		load_pattern(next, pat_bits.size());
	endtask

	// ---------------------------------------------------------------------
	// Count channel: ready drops for a drawn number of cycles after each
	// transfer of a count.
	// ---------------------------------------------------------------------
	initial begin : count_sink
		int hold;
		hold = 0;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				res.ready <= 1'b0;
				hold--;
			end else begin
				res.ready <= 1'b1;
			end
			@(posedge clk);
			if (res.valid && res.ready)
				hold = (stall_max > 0) ? $urandom_range(stall_max, 0) : 0;
		end
	end

	// watchdog: any transfer on any channel restarts it
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (res.valid && res.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("No transfer for %0d cycles, run abandoned.", WATCHDOG_LIMIT);
			$display("** bitmap_2d_rolling_hash_matcher_top: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin : stimulus
		int kind, pw, ph, iw, ih, cut, random_start, counts_start;
		logic [CFG_DATA_W-1:0] pw_d, ph_d, iw_d, ih_d;

		pix.valid  = 1'b0;
		pix.opcode = OP_CLEAR;
		pix.pixel  = 1'b0;
		cfg.valid  = 1'b0;
		cfg.index  = REG_PATTERN_WIDTH;
		cfg.data   = '0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed: reset setting is a 1x1 pattern in a 1x1 image ---
		send_pixel(OP_CLEAR, 1'b0);
		send_pixel(OP_PATTERN, 1'b1);
		send_pixel(OP_PATTERN, 1'b0);   // past the end of the pattern, ignored
		send_pixel(OP_IMAGE, 1'b1);     // each pixel is a whole image: count 1
		send_pixel(OP_IMAGE, 1'b0);     // count 0, same pattern kept
		send_pixel(OP_UNUSED, 1'b1);
		send_pixel(OP_UNUSED, 1'b0);
		send_pixel(OP_CLEAR, 1'b1);
		send_pixel(OP_IMAGE, 1'b0);     // cleared pattern hashes to zero

		// pattern wider than the image: nothing can match
		settle();
		write_config(12'd2, 12'd1, 12'd1, 12'd2);
		send_pixel(OP_CLEAR, 1'b0);
		send_pixel(OP_PATTERN, 1'b1);
		send_pixel(OP_PATTERN, 1'b1);
		send_pixel(OP_IMAGE, 1'b1);
		send_pixel(OP_IMAGE, 1'b1);

		// pattern still loading while the image streams in
		settle();
		write_config(12'd2, 12'd2, 12'd3, 12'd3);
		send_pixel(OP_CLEAR, 1'b0);
		pat_bits = '{1'b1, 1'b0, 1'b1, 1'b1};
		img_bits = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
		load_pattern(0, 2);
		send_image(1'b0, 2, img_bits.size());

		// --- widest setting: 2048-column pattern in a 2048-column row ---
		// pattern width over the top clamps, height has junk above bit 6
		pick_idling();
		settle();
		write_config(12'hFFF, 12'hF81, 12'h800, 12'h001);
		send_pixel(OP_CLEAR, 1'b0);
		make_pattern();
		load_pattern(0, pat_bits.size());
		img_bits = pat_bits;
		send_image(1'b0, pat_bits.size(), img_bits.size());

		// --- tallest setting: 64-row pattern down a 2048-row column ---
		// zero width clamps up to one, heights over the top clamp down
		pick_idling();
		settle();
		write_config(12'h000, 12'hFFF, 12'h001, 12'hFFF);
		send_pixel(OP_CLEAR, 1'b0);
		make_pattern();
		load_pattern(0, pat_bits.size());
		img_bits = new[cur_iw * cur_ih];
		foreach (img_bits[i])
			img_bits[i] = pat_bits[i % pat_bits.size()] ^ ($urandom_range(199, 0) == 0);
		send_image(1'b0, pat_bits.size(), img_bits.size());

		// --- random jobs on small bitmaps ---
		random_start = pixels_sent;
		counts_start = counts_checked;
		while ((pixels_sent - random_start) < RANDOM_PIXELS
				|| (counts_checked - counts_start) < RANDOM_COUNTS) begin
			pick_idling();
			settle();
			kind = $urandom_range(9, 0);
			pw = $urandom_range(4, 1);
			ph = $urandom_range(4, 1);
			if (kind == 9) begin
				// pattern too big for the image in one direction or both
				iw = $urandom_range(6, 1);
				ih = $urandom_range(6, 1);
				if ($urandom_range(1, 0) != 0) pw = iw + $urandom_range(2, 1);
				else ph = ih + $urandom_range(2, 1);
			end else begin
				iw = $urandom_range(10, pw);
				ih = $urandom_range(8, ph);
			end
			pw_d = (pw == 1 && $urandom_range(3, 0) == 0) ? '0 : CFG_DATA_W'(pw);
			iw_d = (iw == 1 && $urandom_range(3, 0) == 0) ? '0 : CFG_DATA_W'(iw);
			ih_d = (ih == 1 && $urandom_range(3, 0) == 0) ? '0 : CFG_DATA_W'(ih);
			ph_d = $urandom;
			ph_d[PH_REG_W-1:0] = (ph == 1 && $urandom_range(3, 0) == 0) ? '0 : PH_REG_W'(ph);
			write_config(pw_d, ph_d, iw_d, ih_d);
			send_pixel(OP_CLEAR, 1'($urandom));
			make_pattern();
			case (kind)
				7: begin
					// part of the pattern up front, the rest mixed into the image
					cut = $urandom_range(pat_bits.size() - 1, 0);
					load_pattern(0, cut);
					make_image($urandom_range(2, 0));
					send_image(1'b0, cut, img_bits.size());
					make_image($urandom_range(2, 0));
					send_image(1'b0, pat_bits.size(), img_bits.size());
				end
				8: begin
					// image cut short and the job cleared
					load_pattern(0, pat_bits.size());
					make_image(1);
					send_image(1'b0, pat_bits.size(), $urandom_range(img_bits.size() - 1, 0));
					send_pixel(OP_CLEAR, 1'($urandom));
				end
				default: begin
					load_pattern(0, pat_bits.size());
					repeat ($urandom_range(3, 1)) begin
						make_image($urandom_range(3, 0));
						send_image(kind < 3, pat_bits.size(), img_bits.size());
					end
				end
			endcase
		end

		settle();
		$display("Run covered %0d pattern and image pixels over %0d register settings,",
			pixels_sent, job_setups);
		$display("sizes from 1 up to 2048, with %0d match counts compared.", counts_checked);
		if (failures == 0)
			$display("** bitmap_2d_rolling_hash_matcher_top: PASSED **");
		else
			$display("** bitmap_2d_rolling_hash_matcher_top: FAILED **");
		$finish;
	end

endmodule
